// ===== hw/rtl/kmp_pkg.sv =====
// shared constants and types of the streaming pattern matcher
package kmp_pkg;

  localparam int unsigned MaxPattern  = 64;
  localparam int unsigned SymbolWidth = 8;
  localparam int unsigned LenWidth    = $clog2(MaxPattern + 1);
  localparam int unsigned PosWidth    = 32;

  typedef enum logic [1:0] {
    OpClear   = 2'd0,
    OpAppend  = 2'd1,
    OpText    = 2'd2,
    OpRestart = 2'd3
  } op_e;

  typedef logic [SymbolWidth-1:0] sym_t;
  typedef logic [LenWidth-1:0]    len_t;
  typedef logic [PosWidth-1:0]    pos_t;

  typedef struct packed {
    logic step;
    logic flush;
    sym_t sym;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/kmp_in_if.sv =====
// input channel: command and symbol
interface kmp_in_if;
  import kmp_pkg::*;

  logic valid;
  logic ready;
  logic [1:0] opcode;
  sym_t symbol;

  modport source (output valid, output opcode, output symbol, input ready);
  modport sink (input valid, input opcode, input symbol, output ready);
endinterface

// ===== hw/rtl/kmp_out_if.sv =====
// output channel: match result and pattern status
interface kmp_out_if;
  import kmp_pkg::*;

  logic valid;
  logic ready;
  logic match;
  pos_t match_start;
  logic overflow_error;
  len_t pattern_length;

  modport source (output valid, output match, output match_start, output overflow_error,
                  output pattern_length, input ready);
  modport sink (input valid, input match, input match_start, input overflow_error,
                input pattern_length, output ready);
endinterface

// ===== hw/rtl/kmp_cell.sv =====
// one pattern position: stored symbol and prefix-match flag
module kmp_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kmp_pkg::cell_ctrl_t ctrl_i,
  input  logic               load_i,
  input  logic               in_use_i,
  input  logic               prev_i,
  output logic               act_o,
  output logic               hit_o
);
  import kmp_pkg::*;

  sym_t pat_q;
  logic act_q, act_d;
  logic extend;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q <= ctrl_i.sym;
    end
  end

  assign extend = prev_i & in_use_i & (pat_q == ctrl_i.sym);

  always_comb begin
    act_d = act_q;
    if (ctrl_i.flush) begin
      act_d = 1'b0;
    end else if (ctrl_i.step) begin
      act_d = extend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  assign act_o = act_q;
  assign hit_o = ctrl_i.step & extend;
endmodule

// ===== hw/rtl/kmp_stream_matcher_core.sv =====
// top level of the streaming pattern matcher
//
// in_i carries commands: clear, append a pattern symbol, text symbol, restart
// the text. Every accepted command gives exactly one transfer on out_o with
// the match flag, start index of the occurrence, overflow flag and the
// pattern length after the command.
// The pattern sits in a row of cells, one per position. Each text symbol
// moves a prefix-match flag one cell along the row, so the handling of a
// command does not depend on the pattern; the result is registered and
// shows in the cycle after the input transfer. A new command is taken in
// the same cycle as the previous result leaves, so one item per cycle is
// sustained while out_o is ready.
// While out_o stalls the result register holds and in_i.ready drops until
// the result has gone.
// first_only_we_i writes first_only_i into the first-only register; write it
// only while the block is idle.
// Reset empties the pattern, restarts the text and clears first-only; the
// stored pattern symbols are not cleared and are only read once loaded.
module kmp_stream_matcher_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  kmp_in_if.sink   in_i,
  kmp_out_if.source out_o,
  input  logic   first_only_we_i,
  input  logic   first_only_i
);
  import kmp_pkg::*;

  localparam len_t LenFull = LenWidth'(MaxPattern);

  len_t len_q, len_d;
  pos_t pos_q, pos_d;
  logic found_q, found_d;
  logic first_only_q;

  logic out_valid_q, out_valid_d;
  logic out_match_q, out_match_d;
  pos_t out_start_q, out_start_d;
  logic out_ovf_q, out_ovf_d;
  len_t out_len_q;

  logic fire;
  op_e  op;
  cell_ctrl_t ctrl;
  logic append_ok;
  logic [MaxPattern-1:0] act, hit, load, in_use, last;
  logic hit_any;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.opcode);
  assign append_ok  = (len_q != LenFull);

  assign ctrl.sym   = in_i.symbol;
  assign ctrl.step  = fire && (op == OpText);
  assign ctrl.flush = fire && ((op == OpClear) || (op == OpRestart) ||
                               ((op == OpAppend) && append_ok));

  for (genvar i = 0; i < MaxPattern; i++) begin : g_cell
    assign load[i]   = fire && (op == OpAppend) && (len_q == LenWidth'(i));
    assign in_use[i] = (len_q > LenWidth'(i));
    assign last[i]   = (len_q == LenWidth'(i + 1));

    kmp_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .load_i   (load[i]),
      .in_use_i (in_use[i]),
      .prev_i   ((i == 0) ? 1'b1 : act[(i == 0) ? 0 : i - 1]),
      .act_o    (act[i]),
      .hit_o    (hit[i])
    );
  end

  assign hit_any = |(hit & last);

  always_comb begin
    len_d       = len_q;
    pos_d       = pos_q;
    found_d     = found_q;
    out_match_d = 1'b0;
    out_start_d = '0;
    out_ovf_d   = 1'b0;
    unique case (op)
      OpClear: begin
        len_d   = '0;
        pos_d   = '0;
        found_d = 1'b0;
      end
      OpAppend: begin
        if (append_ok) begin
          len_d   = len_q + LenWidth'(1);
          pos_d   = '0;
          found_d = 1'b0;
        end else begin
          out_ovf_d = 1'b1;
        end
      end
      OpText: begin
        if (pos_q != '1) begin
          pos_d = pos_q + PosWidth'(1);
        end
        if (hit_any && !(first_only_q && found_q)) begin
          out_match_d = 1'b1;
          out_start_d = pos_q - PosWidth'(len_q) + PosWidth'(1);
          found_d     = 1'b1;
        end
      end
      OpRestart: begin
        pos_d   = '0;
        found_d = 1'b0;
      end
      default: ;
    endcase
  end

  assign out_valid_d = fire || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= '0;
      pos_q        <= '0;
      found_q      <= 1'b0;
      first_only_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (first_only_we_i) begin
        first_only_q <= first_only_i;
      end
      if (fire) begin
        len_q   <= len_d;
        pos_q   <= pos_d;
        found_q <= found_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_match_q <= out_match_d;
      out_start_q <= out_start_d;
      out_ovf_q   <= out_ovf_d;
      out_len_q   <= len_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.match          = out_match_q;
  assign out_o.match_start    = out_start_q;
  assign out_o.overflow_error = out_ovf_q;
  assign out_o.pattern_length = out_len_q;
endmodule

// ===== sim/testbench.sv =====
// testbench for the streaming pattern matcher core: directed and random command streams
`timescale 1ns / 100ps

module testbench;
  import kmp_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned MaxShown      = 10;
  localparam int unsigned RandomItems   = 450;
  localparam int unsigned IdxWidth      = $clog2(MaxPattern);

  typedef struct packed {
    logic match;
    pos_t start;
    logic overflow;
    len_t length;
  } match_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_first_only;

  kmp_in_if  in_ch ();
  kmp_out_if out_ch ();

  kmp_stream_matcher_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_i            (in_ch),
    .out_o           (out_ch),
    .first_only_we_i (cfg_we),
    .first_only_i    (cfg_first_only)
  );

  // predictor state
  sym_t pat_sym  [MaxPattern];
  len_t fail_len [MaxPattern];
  len_t pat_len     = '0;
  len_t build_len   = '0;
  len_t scan_len    = '0;
  pos_t scan_pos    = '0;
  bit   found_flag  = 1'b0;
  bit   first_only_mode = 1'b0;

  match_result_t match_results_q [$];

  int unsigned src_gap_max = 0;
  int unsigned snk_gap_max = 0;
  bit          hold_go     = 1'b0;
  logic        hold_rx     = 1'b0;
  int unsigned sent_count  = 0;
  int unsigned error_count = 0;
  int unsigned match_seen  = 0;
  int unsigned ovf_seen    = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  function automatic void restart_scan();
    scan_len   = '0;
    scan_pos   = '0;
    found_flag = 1'b0;
  endfunction

  function automatic match_result_t predict_match(input op_e op, input sym_t sym);
    match_result_t r;
    int j;
    pos_t idx;
    r = '0;
    case (op)
      OpClear: begin
        pat_len   = '0;
        build_len = '0;
        restart_scan();
      end
      OpAppend: begin
        if (pat_len >= MaxPattern) begin
          r.overflow = 1'b1;
        end else begin
          j = 0;
          if (pat_len > 0) begin
            j = int'(build_len);
            while (j > 0 && pat_sym[IdxWidth'(j)] != sym)
              j = (fail_len[IdxWidth'(j-1)] < j) ? int'(fail_len[IdxWidth'(j-1)]) : 0;
            if (pat_sym[IdxWidth'(j)] == sym) j++;
          end
          pat_sym[IdxWidth'(pat_len)]  = sym;
          fail_len[IdxWidth'(pat_len)] = len_t'(j);
          build_len                    = len_t'(j);
          pat_len++;
          restart_scan();
        end
      end
      OpText: begin
        idx = scan_pos;
        if (scan_pos != '1) scan_pos++;
        if (pat_len > 0) begin
          j = int'(scan_len);
          if (j >= pat_len) j = 0;
          while (j > 0 && pat_sym[IdxWidth'(j)] != sym)
            j = (fail_len[IdxWidth'(j-1)] < j) ? int'(fail_len[IdxWidth'(j-1)]) : 0;
          if (pat_sym[IdxWidth'(j)] == sym) j++;
          if (j == pat_len) begin
            if (!(first_only_mode && found_flag)) begin
              r.match    = 1'b1;
              r.start    = idx - pos_t'(pat_len) + pos_t'(1);
              found_flag = 1'b1;
            end
            j = int'(fail_len[IdxWidth'(j-1)]);
          end
          scan_len = len_t'(j);
        end
      end
      default: restart_scan();
    endcase
    r.length = pat_len;
    return r;
  endfunction

  task automatic send_cmd(input op_e op, input sym_t sym);
    int unsigned gap;
    gap = (src_gap_max == 0) ? 0 : $urandom_range(src_gap_max, 0);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.symbol <= sym;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    match_results_q = {match_results_q, predict_match(op, sym)};
    sent_count++;
  endtask

  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    while (match_results_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_first_only(input bit value);
    cfg_we         <= 1'b1;
    cfg_first_only <= value;
    first_only_mode = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_result();
    match_result_t want;
    match_result_t got;
    got = '{out_ch.match, out_ch.match_start, out_ch.overflow_error, out_ch.pattern_length};
    if (got.match) match_seen++;
    if (got.overflow) ovf_seen++;
    if (match_results_q.size() == 0) begin
      error_count++;
      if (error_count <= MaxShown)
        $display("unexpected transfer: match=%0d start=%0d ovf=%0d len=%0d",
                 got.match, got.start, got.overflow, got.length);
    end else begin
      want = match_results_q.pop_front();
      if (got !== want) begin
        error_count++;
        if (error_count <= MaxShown)
          $display("mismatch: exp match=%0d start=%0d ovf=%0d len=%0d, got %0d %0d %0d %0d",
                   want.match, want.start, want.overflow, want.length,
                   got.match, got.start, got.overflow, got.length);
      end
    end
  endtask

  // result side with random stalls
  initial begin : result_sink
    int unsigned wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        check_result();
        wait_left = (snk_gap_max == 0) ? 0 : $urandom_range(snk_gap_max, 0);
      end else if (wait_left > 0) begin
        wait_left--;
      end
      out_ch.ready <= (wait_left == 0) && !hold_rx;
    end
  end

  // long receiver hold-off
  initial begin : rx_hold_off
    wait (hold_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed_commands();
    send_cmd(OpClear, 8'hFF);
    send_cmd(OpText, 8'h00);
    send_cmd(OpText, 8'hFF);
    send_cmd(OpAppend, 8'hAA);
    send_cmd(OpAppend, 8'hAA);
    repeat (3) send_cmd(OpText, 8'hAA);
    send_cmd(OpText, 8'h55);
    send_cmd(OpRestart, 8'hFF);
    repeat (2) send_cmd(OpText, 8'hAA);
    send_cmd(OpAppend, 8'h00);
    send_cmd(OpText, 8'hAA);
    send_cmd(OpText, 8'hAA);
    send_cmd(OpText, 8'h00);
    send_cmd(OpClear, 8'h5A);
    send_cmd(OpRestart, 8'hA5);
    send_cmd(OpAppend, 8'hFF);
    send_cmd(OpText, 8'hFF);
    send_cmd(OpText, 8'h00);
    send_cmd(OpAppend, 8'h00);
    send_cmd(OpText, 8'hFF);
    send_cmd(OpText, 8'h00);
    settle_idle();
  endtask

  task automatic test_first_only();
    write_first_only(1'b1);
    send_cmd(OpClear, 8'h00);
    send_cmd(OpAppend, 8'h3C);
    send_cmd(OpAppend, 8'hC3);
    repeat (3) begin
      send_cmd(OpText, 8'h3C);
      send_cmd(OpText, 8'hC3);
    end
    send_cmd(OpRestart, 8'h00);
    send_cmd(OpText, 8'h3C);
    send_cmd(OpText, 8'hC3);
    send_cmd(OpText, 8'h3C);
    send_cmd(OpText, 8'hC3);
    settle_idle();
    write_first_only(1'b0);
  endtask

  task automatic test_pattern_overflow();
    sym_t pat [MaxPattern];
    sym_t alpha [2];
    int k;
    alpha[0] = sym_t'($urandom_range(255, 0));
    alpha[1] = ~alpha[0];
    send_cmd(OpClear, 8'h00);
    for (k = 0; k < MaxPattern; k++) begin
      pat[IdxWidth'(k)] = alpha[1'($urandom_range(1, 0))];
      send_cmd(OpAppend, pat[IdxWidth'(k)]);
    end
    repeat (3) send_cmd(OpAppend, sym_t'($urandom_range(255, 0)));
    for (k = 0; k < MaxPattern; k++) send_cmd(OpText, pat[IdxWidth'(k)]);
    for (k = 0; k < MaxPattern; k++) send_cmd(OpText, pat[IdxWidth'(k)]);
    repeat (10) send_cmd(OpText, alpha[1'($urandom_range(1, 0))]);
    settle_idle();
  endtask

  task automatic test_input_stall();
    int k;
    src_gap_max = 0;
    snk_gap_max = 0;
    send_cmd(OpClear, 8'h00);
    send_cmd(OpAppend, 8'h11);
    hold_go = 1'b1;
    for (k = 0; k < 30; k++) send_cmd(OpText, (k % 3 == 0) ? 8'h11 : 8'h22);
    settle_idle();
  endtask

  task automatic test_random_streams();
    sym_t alpha [3];
    sym_t pat [$];
    int unsigned first_item;
    int plen;
    int tlen;
    int k;
    int r;
    first_item = sent_count;
    while (sent_count - first_item < RandomItems) begin
      if ($urandom_range(3, 0) == 0) begin
        settle_idle();
        write_first_only(1'($urandom_range(1, 0)));
        src_gap_max = $urandom_range(1, 0) ? 12 : 0;
        snk_gap_max = $urandom_range(1, 0) ? 12 : 0;
      end
      for (k = 0; k < 3; k++) alpha[2'(k)] = sym_t'($urandom_range(255, 0));
      pat.delete();
      case ($urandom_range(19, 0))
        0:       plen = $urandom_range(64, 17);
        1, 2, 3: plen = $urandom_range(16, 6);
        default: plen = $urandom_range(5, 1);
      endcase
      if ($urandom_range(4, 0) != 0) send_cmd(OpClear, sym_t'($urandom_range(255, 0)));
      for (k = 0; k < plen; k++) begin
        pat = {pat, alpha[2'($urandom_range(1, 0))]};
        send_cmd(OpAppend, pat[k]);
      end
      tlen = $urandom_range(40, 8);
      for (k = 0; k < tlen; k++) begin
        r = $urandom_range(15, 0);
        if (r == 0) begin
          send_cmd(op_e'($urandom_range(3, 0)), sym_t'($urandom_range(255, 0)));
        end else if (r == 1) begin
          foreach (pat[i]) send_cmd(OpText, pat[i]);
        end else if (r == 2) begin
          send_cmd(OpRestart, sym_t'($urandom_range(255, 0)));
        end else begin
          send_cmd(OpText, alpha[2'(($urandom_range(7, 0) == 0) ? 2 : $urandom_range(1, 0))]);
        end
      end
    end
    settle_idle();
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_first_only = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OpClear;
    in_ch.symbol   = '0;
    out_ch.ready   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_gap_max = 12;
    snk_gap_max = 12;
    test_directed_commands();
    test_first_only();
    test_pattern_overflow();
    test_input_stall();
    test_random_streams();

    $display("covered %0d commands with both match modes and stall mixes", sent_count);
    $display("saw %0d reported matches and %0d overflow flags", match_seen, ovf_seen);
    if (error_count == 0 && match_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
